// ----- sv/blpa_pkg.sv -----
// ---------------------------------------------------------------------------
// blpa_pkg
// Shared types and constants for the line pixel address generator.
// ---------------------------------------------------------------------------
`default_nettype none

package blpa_pkg;

    // fixed field widths
    localparam int ADDR_W      = 32;
    localparam int PITCH_W     = 12;
    localparam int COLOUR_W    = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    // widest coordinate the design supports; queue fields are sized for it
    localparam int COORD_MAX_W = 16;
    localparam int DEC_MAX_W   = COORD_MAX_W + 2;

    // command queue depth
    localparam int QUEUE_DEPTH = 4;

    // register reset values
    localparam logic [PITCH_W-1:0] PITCH_RESET = 12'd640;
    localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd0;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_PITCH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BASE = 1'b1;

    // item opcodes
    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t                   op;
        logic [ADDR_W-1:0]     base_off;
        logic [ADDR_W-1:0]     diag_step;
        logic [ADDR_W-1:0]     straight_step;
        logic [DEC_MAX_W-1:0]  decision;
        logic [DEC_MAX_W-1:0]  diag_adjust;
        logic [DEC_MAX_W-2:0]  straight_adjust;
        logic [COORD_MAX_W:0]  pixel_count;
        logic [COLOUR_W-1:0]   colour;
    } line_cmd_t;

endpackage

`default_nettype wire

// ----- sv/blpa_if.sv -----
// ---------------------------------------------------------------------------
// blpa_cmd_if / blpa_pixel_if
// Valid/ready channels for command items and pixel items.
// ---------------------------------------------------------------------------
`default_nettype none

interface blpa_cmd_if #(parameter int COORD_WIDTH = 11);
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [COORD_WIDTH-1:0]        x_start;
    logic [COORD_WIDTH-1:0]        y_start;
    logic [COORD_WIDTH-1:0]        x_end;
    logic [COORD_WIDTH-1:0]        y_end;
    logic [blpa_pkg::COLOUR_W-1:0] colour;

    modport source (output valid, op, x_start, y_start, x_end, y_end, colour,
                    input ready);
    modport sink   (input valid, op, x_start, y_start, x_end, y_end, colour,
                    output ready);
endinterface

interface blpa_pixel_if;
    logic                          valid;
    logic                          ready;
    logic [blpa_pkg::ADDR_W-1:0]   pixel_address;
    logic [blpa_pkg::COLOUR_W-1:0] pixel_colour;
    logic                          last;

    modport source (output valid, pixel_address, pixel_colour, last,
                    input ready);
    modport sink   (input valid, pixel_address, pixel_colour, last,
                    output ready);
endinterface

`default_nettype wire

// ----- sv/bresenham_line_pixel_address.sv -----
// ---------------------------------------------------------------------------
// bresenham_line_pixel_address
// Line generator producing frame-buffer byte addresses, one pixel per tick while a line is drawing.
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  cmd       in   valid/ready    op, x_start, y_start, x_end, y_end, colour
//  pixel     out  valid/ready    pixel_address, pixel_colour, last
//  cfg       in   cfg_we         cfg_index, cfg_data (row_pitch, frame_base)
//
//  one item per clock sustained while pixel does not stall; a tick item passes
//  the input register, the queue and the output register before its pixel
//  leaves. start setup costs one multiply in the front stage.
//  reset clears the line state and loads row_pitch 640, frame_base 0.
//  the 4-entry queue lets the front keep taking items while pixel stalls.
//
`default_nettype none

module bresenham_line_pixel_address #(
    parameter int COORD_WIDTH = 11
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    blpa_cmd_if.sink                               cmd,
    blpa_pixel_if.source                           pixel,
    input  wire logic                              cfg_we,
    input  wire logic [blpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [blpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [blpa_pkg::ADDR_W-1:0] frame_base;
    logic                        q_push;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_empty;
    blpa_pkg::line_cmd_t         push_data;
    blpa_pkg::line_cmd_t         pop_data;

    // setup front
    blpa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .frame_base (frame_base),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (push_data)
    );

    // command queue
    blpa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    // stepping back end
    blpa_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_base (frame_base),
        .q_data     (pop_data),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .pixel      (pixel)
    );

endmodule

`default_nettype wire

// ----- sv/blpa_front.sv -----
// ---------------------------------------------------------------------------
// blpa_front
// Input register, config registers and line setup classification.
// ---------------------------------------------------------------------------
`default_nettype none

module blpa_front #(
    parameter int COORD_WIDTH = 11
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    blpa_cmd_if.sink                               cmd,
    input  wire logic                              cfg_we,
    input  wire logic [blpa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [blpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic      [blpa_pkg::ADDR_W-1:0]       frame_base,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output blpa_pkg::line_cmd_t                    q_data
);

    localparam int CW       = COORD_WIDTH;
    localparam int ADDR_W   = blpa_pkg::ADDR_W;
    localparam int PITCH_W  = blpa_pkg::PITCH_W;
    localparam int COLOUR_W = blpa_pkg::COLOUR_W;
    localparam int DMAX     = blpa_pkg::DEC_MAX_W;
    localparam int CMAX     = blpa_pkg::COORD_MAX_W;
    localparam int DW       = CW + 2;
    localparam int PROD_W   = CW + PITCH_W;

    logic [PITCH_W-1:0]  pitch_reg;
    logic [ADDR_W-1:0]   base_reg;

    logic                s1_valid_reg;
    logic                s1_op_reg;
    logic [CW-1:0]       xa_reg;
    logic [CW-1:0]       ya_reg;
    logic [CW-1:0]       xb_reg;
    logic [CW-1:0]       yb_reg;
    logic [COLOUR_W-1:0] colour_reg;

    logic                dx_neg;
    logic                dy_neg;
    logic [CW-1:0]       adx;
    logic [CW-1:0]       ady;
    logic                x_major;
    logic [CW-1:0]       major;
    logic [CW-1:0]       minor;
    logic [ADDR_W-1:0]   col_step;
    logic [ADDR_W-1:0]   row_step;
    logic [ADDR_W-1:0]   pitch_ext;
    logic [PROD_W-1:0]   row_prod;
    logic [DW-1:0]       decision;
    logic [DW-1:0]       diag_adjust;
    logic [CW:0]         straight_adjust;
    logic [CW:0]         pixel_count;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg <= blpa_pkg::PITCH_RESET;
            base_reg  <= blpa_pkg::BASE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                blpa_pkg::CFG_ROW_PITCH:  pitch_reg <= cfg_data[PITCH_W-1:0];
                blpa_pkg::CFG_FRAME_BASE: base_reg  <= cfg_data[ADDR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign frame_base = base_reg;

    // input stage: takes a new item when it holds none or the held one moves on
    assign cmd.ready = !s1_valid_reg || !q_full;
    assign q_push    = s1_valid_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_op_reg  <= cmd.op;
            xa_reg     <= cmd.x_start;
            ya_reg     <= cmd.y_start;
            xb_reg     <= cmd.x_end;
            yb_reg     <= cmd.y_end;
            colour_reg <= cmd.colour;
        end
    end

    // extents, steps and decision terms
    always_comb
    begin
        dx_neg   = xb_reg < xa_reg;
        dy_neg   = yb_reg < ya_reg;
        adx      = dx_neg ? (xa_reg - xb_reg) : (xb_reg - xa_reg);
        ady      = dy_neg ? (ya_reg - yb_reg) : (yb_reg - ya_reg);
        // equal extents count as y major
        x_major  = adx > ady;
        major    = x_major ? adx : ady;
        minor    = x_major ? ady : adx;

        pitch_ext = ADDR_W'(pitch_reg);
        col_step  = dx_neg ? {ADDR_W{1'b1}} : ADDR_W'(1);
        row_step  = dy_neg ? (ADDR_W'(0) - pitch_ext) : pitch_ext;

        row_prod  = PROD_W'(ya_reg) * PROD_W'(pitch_reg);

        decision        = {1'b0, minor, 1'b0} - {2'b00, major};
        diag_adjust     = {1'b0, minor, 1'b0} - {1'b0, major, 1'b0};
        straight_adjust = {minor, 1'b0};
        pixel_count     = {1'b0, major} + (CW+1)'(1);

        q_data.op              = blpa_pkg::op_t'(s1_op_reg);
        q_data.base_off        = ADDR_W'(row_prod) + ADDR_W'(xa_reg);
        q_data.diag_step       = col_step + row_step;
        q_data.straight_step   = x_major ? col_step : row_step;
        q_data.decision        = DMAX'(decision);
        q_data.diag_adjust     = DMAX'(diag_adjust);
        q_data.straight_adjust = (DMAX-1)'(straight_adjust);
        q_data.pixel_count     = (CMAX+1)'(pixel_count);
        q_data.colour          = colour_reg;
    end

endmodule

`default_nettype wire

// ----- sv/blpa_queue.sv -----
// ---------------------------------------------------------------------------
// blpa_queue
// Short command queue between the setup front and the stepping back.
// ---------------------------------------------------------------------------
`default_nettype none

module blpa_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire blpa_pkg::line_cmd_t  push_data,
    output logic                      full,
    input  wire logic                 pop,
    output blpa_pkg::line_cmd_t       pop_data,
    output logic                      empty
);

    localparam int DEPTH = blpa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    blpa_pkg::line_cmd_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign empty    = count_reg == CNT_W'(0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                             : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                             : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- sv/blpa_back.sv -----
// ---------------------------------------------------------------------------
// blpa_back
// Line stepping engine with registered pixel output.
// ---------------------------------------------------------------------------
`default_nettype none

module blpa_back #(
    parameter int COORD_WIDTH = 11
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [blpa_pkg::ADDR_W-1:0] frame_base,
    input  wire blpa_pkg::line_cmd_t         q_data,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    blpa_pixel_if.source                     pixel
);

    localparam int CW       = COORD_WIDTH;
    localparam int ADDR_W   = blpa_pkg::ADDR_W;
    localparam int COLOUR_W = blpa_pkg::COLOUR_W;
    localparam int DW       = CW + 2;

    logic                active_reg,      active_next;
    logic [ADDR_W-1:0]   addr_reg,        addr_next;
    logic [DW-1:0]       decision_reg,    decision_next;
    logic [CW:0]         left_reg,        left_next;
    logic [ADDR_W-1:0]   diag_step_reg,   diag_step_next;
    logic [ADDR_W-1:0]   str_step_reg,    str_step_next;
    logic [DW-1:0]       diag_adj_reg,    diag_adj_next;
    logic [CW:0]         str_adj_reg,     str_adj_next;
    logic [COLOUR_W-1:0] colour_reg,      colour_next;

    logic                out_valid_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [COLOUR_W-1:0] out_colour_reg;
    logic                out_last_reg;

    logic                can_take;
    logic                is_start;
    logic                emit;
    logic                final_pixel;

    assign can_take    = !out_valid_reg || pixel.ready;
    assign q_pop       = !q_empty && can_take;
    assign is_start    = q_data.op == blpa_pkg::OP_START;
    assign emit        = q_pop && !is_start && active_reg;
    assign final_pixel = left_reg == (CW+1)'(1);

    // line state: load on start, step on tick
    always_comb
    begin
        active_next    = active_reg;
        addr_next      = addr_reg;
        decision_next  = decision_reg;
        left_next      = left_reg;
        diag_step_next = diag_step_reg;
        str_step_next  = str_step_reg;
        diag_adj_next  = diag_adj_reg;
        str_adj_next   = str_adj_reg;
        colour_next    = colour_reg;
        if (q_pop && is_start)
        begin
            active_next    = 1'b1;
            addr_next      = frame_base + q_data.base_off;
            decision_next  = q_data.decision[DW-1:0];
            left_next      = q_data.pixel_count[CW:0];
            diag_step_next = q_data.diag_step;
            str_step_next  = q_data.straight_step;
            diag_adj_next  = q_data.diag_adjust[DW-1:0];
            str_adj_next   = q_data.straight_adjust[CW:0];
            colour_next    = q_data.colour;
        end
        else if (emit)
        begin
            // non-negative decision takes the diagonal step
            if (!decision_reg[DW-1])
            begin
                addr_next     = addr_reg + diag_step_reg;
                decision_next = decision_reg + diag_adj_reg;
            end
            else
            begin
                addr_next     = addr_reg + str_step_reg;
                decision_next = decision_reg + {1'b0, str_adj_reg};
            end
            left_next   = left_reg - (CW+1)'(1);
            active_next = !final_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            addr_reg      <= '0;
            decision_reg  <= '0;
            left_reg      <= '0;
            diag_step_reg <= '0;
            str_step_reg  <= '0;
            diag_adj_reg  <= '0;
            str_adj_reg   <= '0;
            colour_reg    <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            addr_reg      <= addr_next;
            decision_reg  <= decision_next;
            left_reg      <= left_next;
            diag_step_reg <= diag_step_next;
            str_step_reg  <= str_step_next;
            diag_adj_reg  <= diag_adj_next;
            str_adj_reg   <= str_adj_next;
            colour_reg    <= colour_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pixel.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_addr_reg   <= addr_reg;
            out_colour_reg <= colour_reg;
            out_last_reg   <= final_pixel;
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_address = out_addr_reg;
    assign pixel.pixel_colour  = out_colour_reg;
    assign pixel.last          = out_last_reg;

    // checks
    a_active_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> left_reg != '0)
        else $error("active line with no pixels left");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && final_pixel) |=> !active_reg)
        else $error("line still active after its last pixel");

    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && is_start) |=>
            (active_reg && left_reg == $past(q_data.pixel_count[CW:0])))
        else $error("start item did not load the line");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(emit))
        else $error("pixel item appeared without a tick");

endmodule

`default_nettype wire

// ----- bench/tb_bresenham_line_pixel_address.sv -----
// ---------------------------------------------------------------------------
// tb_bresenham_line_pixel_address
// Self-checking bench for the line pixel address generator: a scoreboard
// class steps its own Bresenham predictor on every accepted command item and
// compares each pixel item, field by field, against the oldest prediction.
// Directed lines come first, then random phases under several register
// settings, with random gaps on both channels and one long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bresenham_line_pixel_address;

    localparam int ADDR_W      = blpa_pkg::ADDR_W;
    localparam int COLOUR_W    = blpa_pkg::COLOUR_W;
    localparam int PITCH_W     = blpa_pkg::PITCH_W;
    localparam int CFG_INDEX_W = blpa_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = blpa_pkg::CFG_DATA_W;

    localparam int COORD_W     = 11;
    localparam int COORD_TOP   = (1 << COORD_W) - 1;
    localparam int SETTLE      = 16;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 100;
    localparam int PHASES      = 7;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [COLOUR_W-1:0] colour;
        logic                last_px;
    } pixel_t;

    // line predictor plus the queue of pixels it still expects to see
    class pixel_tracker;
        logic [PITCH_W-1:0]  pitch;
        logic [ADDR_W-1:0]   base;
        bit                  drawing;
        logic [ADDR_W-1:0]   cur_addr;
        logic signed [13:0]  err;
        logic [11:0]         remaining;
        logic [ADDR_W-1:0]   diag_step;
        logic [ADDR_W-1:0]   axis_step;
        logic signed [13:0]  diag_adj;
        logic [12:0]         axis_adj;
        logic [COLOUR_W-1:0] colour;
        pixel_t              pending_pixels[$];
        int                  errors;

        function new();
            pitch     = blpa_pkg::PITCH_RESET;
            base      = blpa_pkg::BASE_RESET;
            drawing   = 0;
            cur_addr  = '0;
            err       = '0;
            remaining = '0;
            diag_step = '0;
            axis_step = '0;
            diag_adj  = '0;
            axis_adj  = '0;
            colour    = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == blpa_pkg::CFG_ROW_PITCH)
                pitch = data[PITCH_W-1:0];
            else
                base = data[ADDR_W-1:0];
        endfunction

        // returns 1 when the item changes state or yields a pixel
        function bit take_command(blpa_pkg::op_t op, coord_t xs, coord_t ys, coord_t xe,
                                  coord_t ye, logic [COLOUR_W-1:0] col);
            int          dx;
            int          dy;
            int          major;
            int          minor;
            logic [31:0] col_step;
            logic [31:0] row_step;
            pixel_t      px;
            if (op == blpa_pkg::OP_START)
            begin
                dx       = int'(xe) - int'(xs);
                dy       = int'(ye) - int'(ys);
                col_step = 32'd1;
                row_step = {20'd0, pitch};
                if (dx < 0)
                begin
                    dx       = -dx;
                    col_step = '1;
                end
                if (dy < 0)
                begin
                    dy       = -dy;
                    row_step = 32'd0 - {20'd0, pitch};
                end
                diag_step = col_step + row_step;
                // equal extents step along y
                if (dx > dy)
                begin
                    major     = dx;
                    minor     = dy;
                    axis_step = col_step;
                end
                else
                begin
                    major     = dy;
                    minor     = dx;
                    axis_step = row_step;
                end
                cur_addr  = base + 32'(ys) * {20'd0, pitch} + 32'(xs);
                err       = 14'(2 * minor - major);
                axis_adj  = 13'(2 * minor);
                diag_adj  = 14'(2 * minor - 2 * major);
                remaining = 12'(major + 1);
                colour    = col;
                drawing   = 1;
                return 1;
            end
            // tick while idle is ignored
            if (!drawing)
                return 0;
            px.addr    = cur_addr;
            px.colour  = colour;
            px.last_px = (remaining == 12'd1);
            pending_pixels.push_back(px);
            if (err >= 0)
            begin
                cur_addr = cur_addr + diag_step;
                err      = err + diag_adj;
            end
            else
            begin
                cur_addr = cur_addr + axis_step;
                err      = err + $signed({1'b0, axis_adj});
            end
            remaining = remaining - 12'd1;
            if (remaining == 12'd0)
                drawing = 0;
            return 1;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR %0t: %s", $realtime, msg);
        endtask

        task check_pixel(logic [ADDR_W-1:0] addr, logic [COLOUR_W-1:0] col, logic fin);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("pixel %h/%h/%b with none expected", addr, col, fin));
                return;
            end
            want = pending_pixels.pop_front();
            if (addr !== want.addr)
                report($sformatf("pixel_address %h, expected %h", addr, want.addr));
            if (col !== want.colour)
                report($sformatf("pixel_colour %h, expected %h", col, want.colour));
            if (fin !== want.last_px)
                report($sformatf("last %b, expected %b at %h", fin, want.last_px, want.addr));
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    blpa_cmd_if #(.COORD_WIDTH(COORD_W)) cmd_ch ();
    blpa_pixel_if                        pix_ch ();

    pixel_tracker sb = new();

    bit offering;
    bit src_calm;
    int items_sent;
    int items_done;
    int pixels_seen;
    int cycles;

    bresenham_line_pixel_address #(
        .COORD_WIDTH (COORD_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .pixel     (pix_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // run limit
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // pixel receiver with random gaps and one long stall
    initial
    begin : pixel_sink
        int  wait_left;
        bit  sink_calm;
        bit  held;
        wait_left   = 0;
        sink_calm   = 0;
        held        = 0;
        pixels_seen = 0;
        pix_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pix_ch.valid && pix_ch.ready)
            begin
                sb.check_pixel(pix_ch.pixel_address, pix_ch.pixel_colour, pix_ch.last);
                pixels_seen++;
                if (pixels_seen % 64 == 0)
                    sink_calm = ($urandom_range(0, 2) == 0);
                wait_left = sink_calm ? 0 : $urandom_range(0, 10);
                if (pixels_seen == 120 && !held)
                begin
                    wait_left = LONG_HOLD;
                    held      = 1;
                end
            end
            else if (wait_left > 0)
            begin
                wait_left--;
            end
            pix_ch.ready <= (wait_left == 0);
        end
    end

    // offer one command item and wait for it to be taken
    task automatic send_item(input blpa_pkg::op_t op, input coord_t xs, input coord_t ys,
                             input coord_t xe, input coord_t ye,
                             input logic [COLOUR_W-1:0] col);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            if (offering)
                cmd_ch.valid <= 1'b0;
            offering = 0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.op      <= op;
        cmd_ch.x_start <= xs;
        cmd_ch.y_start <= ys;
        cmd_ch.x_end   <= xe;
        cmd_ch.y_end   <= ye;
        cmd_ch.colour  <= col;
        offering = 1;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (sb.take_command(op, xs, ys, xe, ye, col))
            items_done++;
        items_sent++;
        if (items_sent % 40 == 0)
            src_calm = ($urandom_range(0, 2) == 0);
    endtask

    // tick with junk in the ignored fields
    task automatic send_tick();
        send_item(blpa_pkg::OP_TICK, coord_t'($urandom_range(0, COORD_TOP)),
                  coord_t'($urandom_range(0, COORD_TOP)),
                  coord_t'($urandom_range(0, COORD_TOP)),
                  coord_t'($urandom_range(0, COORD_TOP)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic draw_line(input coord_t xs, input coord_t ys, input coord_t xe,
                             input coord_t ye, input logic [COLOUR_W-1:0] col,
                             input int ticks);
        send_item(blpa_pkg::OP_START, xs, ys, xe, ye, col);
        repeat (ticks) send_tick();
    endtask

    function automatic int line_length(coord_t xs, coord_t ys, coord_t xe, coord_t ye);
        int dx;
        int dy;
        dx = (xe > xs) ? int'(xe) - int'(xs) : int'(xs) - int'(xe);
        dy = (ye > ys) ? int'(ye) - int'(ys) : int'(ys) - int'(ye);
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    // endpoint near c, random direction, kept on the grid
    function automatic coord_t near_coord(coord_t c, int mag);
        int v;
        v = int'(c);
        if ($urandom_range(0, 1) == 1 && v + mag <= COORD_TOP)
            return coord_t'(v + mag);
        if (v >= mag)
            return coord_t'(v - mag);
        return coord_t'(v + mag);
    endfunction

    task automatic stop_offering();
        if (offering)
            cmd_ch.valid <= 1'b0;
        offering = 0;
    endtask

    // let every expected pixel out and the pipeline empty
    task automatic drain();
        stop_offering();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // random line traffic: mostly complete short lines, some cut short, some noise
    task automatic run_phase(input int budget);
        int     target;
        int     kind;
        int     len;
        coord_t xs;
        coord_t ys;
        coord_t xe;
        coord_t ye;
        target = items_done + budget;
        while (items_done < target)
        begin
            kind = $urandom_range(0, 99);
            xs   = coord_t'($urandom_range(0, COORD_TOP));
            ys   = coord_t'($urandom_range(0, COORD_TOP));
            if (kind < 70)
            begin
                xe  = near_coord(xs, $urandom_range(0, 12));
                ye  = near_coord(ys, $urandom_range(0, 12));
                len = line_length(xs, ys, xe, ye);
                draw_line(xs, ys, xe, ye, 8'($urandom_range(0, 255)), len);
                if ($urandom_range(0, 3) == 0)
                    send_tick();
            end
            else if (kind < 75)
            begin
                xe  = near_coord(xs, $urandom_range(0, 150));
                ye  = near_coord(ys, $urandom_range(0, 150));
                len = line_length(xs, ys, xe, ye);
                draw_line(xs, ys, xe, ye, 8'($urandom_range(0, 255)), len);
            end
            else if (kind < 88)
            begin
                // long line replaced by the next start
                xe = coord_t'($urandom_range(0, COORD_TOP));
                ye = coord_t'($urandom_range(0, COORD_TOP));
                draw_line(xs, ys, xe, ye, 8'($urandom_range(0, 255)),
                          $urandom_range(0, 20));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    send_item(blpa_pkg::op_t'($urandom_range(0, 1)),
                              coord_t'($urandom_range(0, COORD_TOP)),
                              coord_t'($urandom_range(0, COORD_TOP)),
                              coord_t'($urandom_range(0, COORD_TOP)),
                              coord_t'($urandom_range(0, COORD_TOP)),
                              8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [PITCH_W-1:0] pitch;
        logic [ADDR_W-1:0]  base;
        logic [19:0]        junk;
        offering   = 0;
        src_calm   = 0;
        items_sent = 0;
        items_done = 0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.op      <= blpa_pkg::OP_TICK;
        cmd_ch.x_start <= '0;
        cmd_ch.y_start <= '0;
        cmd_ch.x_end   <= '0;
        cmd_ch.y_end   <= '0;
        cmd_ch.colour  <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= blpa_pkg::CFG_ROW_PITCH;
        cfg_data       <= '0;
        wait (rst_n);
        @(posedge clk);

        // directed lines at reset register values
        send_tick();
        draw_line(11'd0, 11'd0, 11'd0, 11'd0, 8'h00, 1);
        draw_line(11'd2047, 11'd2047, 11'd2047, 11'd2047, 8'hFF, 1);
        draw_line(11'd10, 11'd10, 11'd6, 11'd13, 8'h5A, 5);
        draw_line(11'd3, 11'd3, 11'd5, 11'd5, 8'hA5, 3);
        // start while busy replaces the diagonal
        draw_line(11'd0, 11'd2047, 11'd2047, 11'd0, 8'h81, 2);
        draw_line(11'd2047, 11'd0, 11'd2047, 11'd3, 8'h7E, 4);
        send_tick();
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            junk = 20'($urandom());
            case (p)
                0:
                begin
                    pitch = 12'd2048;
                    base  = 32'hFFFF_FFF0;
                end
                1:
                begin
                    pitch = 12'd1;
                    base  = 32'h0000_0000;
                end
                2:
                begin
                    pitch = 12'd0;
                    base  = 32'hFFFF_FFFF;
                end
                3:
                begin
                    pitch = 12'hFFF;
                    base  = 32'($urandom());
                end
                default:
                begin
                    pitch = 12'($urandom_range(1, 2048));
                    base  = 32'($urandom());
                end
            endcase
            write_reg(blpa_pkg::CFG_ROW_PITCH, {junk, pitch});
            write_reg(blpa_pkg::CFG_FRAME_BASE, base);
            run_phase(PHASE_ITEMS);
            drain();
        end

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- bresenham_line_pixel_address.f -----
sv/blpa_pkg.sv
sv/blpa_if.sv
sv/blpa_front.sv
sv/blpa_queue.sv
sv/blpa_back.sv
sv/bresenham_line_pixel_address.sv
bench/tb_bresenham_line_pixel_address.sv
